// ----- src/clp_pkg.sv -----
package clp_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ARG_W      = 34;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned TOK_W      = 9;

  localparam logic [POS_W-1:0] POS_START   = 6'd0;
  localparam logic [POS_W-1:0] POS_ASSIGN  = 6'd1;
  localparam logic [POS_W-1:0] POS_SUM     = 6'd9;
  localparam logic [POS_W-1:0] POS_CLEAR   = 6'd22;
  localparam logic [POS_W-1:0] SCRIPT_LEN  = 6'd31;
  localparam logic [POS_W-1:0] POS_DISCARD = 6'd63;

  localparam logic [TOK_W-1:0] TOK_NUM = 9'h100;
  localparam logic [TOK_W-1:0] TOK_EOL = 9'h101;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_C    = 8'h63;

  typedef enum logic [1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_SUM    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ARG_W-1:0] arg_first;
    logic [ARG_W-1:0] arg_second;
    logic [ARG_W-1:0] arg_third;
  } result_t;

  // expected token at each grammar position; past the script reads as end of line
  function automatic logic [TOK_W-1:0] token_at(input logic [POS_W-1:0] pos);
    logic [TOK_W-1:0] tok;
    case (pos)
      6'd1:    tok = {1'b0, 8'h66};  // f
      6'd2:    tok = {1'b0, 8'h28};  // (
      6'd3:    tok = TOK_NUM;
      6'd4:    tok = {1'b0, 8'h29};  // )
      6'd5:    tok = {1'b0, 8'h3A};  // :
      6'd6:    tok = {1'b0, 8'h3D};  // =
      6'd7:    tok = TOK_NUM;
      6'd8:    tok = TOK_EOL;
      6'd9:    tok = {1'b0, 8'h73};  // s
      6'd10:   tok = {1'b0, 8'h75};  // u
      6'd11:   tok = {1'b0, 8'h6D};  // m
      6'd12:   tok = {1'b0, 8'h61};  // a
      6'd13:   tok = {1'b0, 8'h28};  // (
      6'd14:   tok = TOK_NUM;
      6'd15:   tok = {1'b0, 8'h2C};  // ,
      6'd16:   tok = TOK_NUM;
      6'd17:   tok = {1'b0, 8'h2E};  // .
      6'd18:   tok = {1'b0, 8'h2E};  // .
      6'd19:   tok = TOK_NUM;
      6'd20:   tok = {1'b0, 8'h29};  // )
      6'd21:   tok = TOK_EOL;
      6'd22:   tok = {1'b0, 8'h63};  // c
      6'd23:   tok = {1'b0, 8'h7A};  // z
      6'd24:   tok = {1'b0, 8'h79};  // y
      6'd25:   tok = {1'b0, 8'h73};  // s
      6'd26:   tok = {1'b0, 8'h63};  // c
      6'd27:   tok = {1'b0, 8'h28};  // (
      6'd28:   tok = TOK_NUM;
      6'd29:   tok = {1'b0, 8'h29};  // )
      6'd30:   tok = TOK_EOL;
      6'd0:    tok = 9'h000;
      default: tok = TOK_EOL;
    endcase
    return tok;
  endfunction

  // which saved slot a number at this position lands in (0: none)
  function automatic logic [1:0] slot_of(input logic [POS_W-1:0] pos);
    logic [1:0] s;
    case (pos)
      6'd3, 6'd14, 6'd28: s = 2'd1;
      6'd7, 6'd16:        s = 2'd2;
      6'd19:              s = 2'd3;
      default:            s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- src/clp_core.sv -----
module clp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            char_i,
  input  logic                  eos_i,
  output clp_pkg::result_t      result_o
);

  logic [clp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [clp_pkg::ARG_W-1:0] num_q, num_d;
  logic [clp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [clp_pkg::ARG_W-1:0] first_q, first_d;
  logic [clp_pkg::ARG_W-1:0] second_q, second_d;

  logic                      is_digit;
  logic [clp_pkg::ARG_W-1:0] digit;
  logic [clp_pkg::ARG_W-1:0] num_x10;

  assign is_digit = (char_i >= clp_pkg::CH_ZERO) && (char_i <= clp_pkg::CH_NINE);
  assign digit    = {{(clp_pkg::ARG_W-4){1'b0}}, char_i[3:0]};
  assign num_x10  = {num_q[clp_pkg::ARG_W-4:0], 3'b000} +
                    {num_q[clp_pkg::ARG_W-2:0], 1'b0};

  always_comb begin : step_logic
    logic [clp_pkg::TOK_W-1:0] tok;
    logic                      done;
    logic                      err;
    logic                      emit;
    logic                      clr;
    pos_d    = pos_q;
    num_d    = num_q;
    cnt_d    = cnt_q;
    first_d  = first_q;
    second_d = second_q;
    result_o = '0;
    done     = 1'b0;
    err      = 1'b0;
    emit     = 1'b0;
    clr      = 1'b0;
    tok      = clp_pkg::token_at(pos_q);

    if (eos_i) begin
      if (pos_q != clp_pkg::POS_START && pos_q < clp_pkg::SCRIPT_LEN) begin
        if (tok == clp_pkg::TOK_NUM && cnt_q != '0) begin
          if (clp_pkg::slot_of(pos_d) == 2'd1) first_d = num_q;
          else if (clp_pkg::slot_of(pos_d) == 2'd2) second_d = num_q;
          pos_d = pos_d + 6'd1;
        end
        if (clp_pkg::token_at(pos_d) == clp_pkg::TOK_EOL) emit = 1'b1;
        else result_o.valid = 1'b1;
      end
      clr = 1'b1;
    end else if (pos_q == clp_pkg::POS_START) begin
      if (char_i == clp_pkg::CH_F) pos_d = clp_pkg::POS_ASSIGN + 6'd1;
      else if (char_i == clp_pkg::CH_S) pos_d = clp_pkg::POS_SUM + 6'd1;
      else if (char_i == clp_pkg::CH_C) pos_d = clp_pkg::POS_CLEAR + 6'd1;
      else err = 1'b1;
    end else if (pos_q >= clp_pkg::SCRIPT_LEN) begin
      if (char_i == clp_pkg::CH_NL) clr = 1'b1;
    end else begin
      if (tok == clp_pkg::TOK_NUM) begin
        if (cnt_q == '0) begin
          done = 1'b1;
          if (char_i == clp_pkg::CH_ZERO) begin
            num_d = '0;
            if (clp_pkg::slot_of(pos_q) == 2'd1) first_d = '0;
            else if (clp_pkg::slot_of(pos_q) == 2'd2) second_d = '0;
            pos_d = pos_q + 6'd1;
          end else if (!is_digit) begin
            err = 1'b1;
          end else begin
            num_d = digit;
            cnt_d = clp_pkg::CNT_W'(1);
          end
        end else if (is_digit && cnt_q < clp_pkg::CNT_W'(clp_pkg::MAX_DIGITS)) begin
          done  = 1'b1;
          num_d = num_x10 + digit;
          cnt_d = cnt_q + clp_pkg::CNT_W'(1);
        end else begin
          if (clp_pkg::slot_of(pos_q) == 2'd1) first_d = num_q;
          else if (clp_pkg::slot_of(pos_q) == 2'd2) second_d = num_q;
          cnt_d = '0;
          pos_d = pos_q + 6'd1;
          tok   = clp_pkg::token_at(pos_d);
        end
      end
      if (!done) begin
        if (tok == clp_pkg::TOK_EOL) begin
          if (char_i != clp_pkg::CH_NL) begin
            err = 1'b1;
          end else begin
            emit = 1'b1;
            clr  = 1'b1;
          end
        end else if ({1'b0, char_i} == tok) begin
          pos_d = pos_d + 6'd1;
        end else begin
          err = 1'b1;
        end
      end
    end

    if (emit) begin
      result_o.valid = 1'b1;
      if (pos_d < clp_pkg::POS_SUM) begin
        result_o.kind       = clp_pkg::KIND_ASSIGN;
        result_o.arg_first  = first_d;
        result_o.arg_second = second_d;
      end else if (pos_d < clp_pkg::POS_CLEAR) begin
        result_o.kind       = clp_pkg::KIND_SUM;
        result_o.arg_first  = first_d;
        result_o.arg_second = second_d;
        result_o.arg_third  = num_q;
      end else begin
        result_o.kind       = clp_pkg::KIND_CLEAR;
        result_o.arg_first  = first_d;
      end
    end else if (result_o.valid || err) begin
      result_o.valid = 1'b1;
      result_o.kind  = clp_pkg::KIND_ERROR;
    end

    if (err || clr) begin
      num_d    = '0;
      cnt_d    = '0;
      first_d  = '0;
      second_d = '0;
      pos_d    = clp_pkg::POS_START;
      if (err && !eos_i && char_i != clp_pkg::CH_NL) pos_d = clp_pkg::POS_DISCARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= clp_pkg::POS_START;
      num_q    <= '0;
      cnt_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      num_q    <= num_d;
      cnt_q    <= cnt_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// ----- src/command_line_parser.sv -----
// Line command recognizer: takes one character word per cycle (tlast marks end of
// stream and carries no character) and recognizes f(K):=V, suma(T,L..R) and
// czysc(T), each ended by a newline or end of stream. A finished line gives one
// result word (tuser kind: 0 assignment, 1 sum, 2 clear, 3 syntax error); any
// mismatch gives one error word and drops the rest of the line. A new character
// is taken every cycle unless a result word waits; a character passes through the
// input register and the combinational grammar step with its multiply-by-ten
// accumulate on its way to the result register. The input side stalls only while a
// result word waits to be taken.
module command_line_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] char_byte
  input  logic          s_axis_tlast,   // end_of_stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // [33:0] arg_first, [67:34] arg_second,
                                        // [101:68] arg_third, [103:102] zero
  output logic [1:0]    m_axis_tuser    // event_kind
);

  logic                  in_v_q, in_v_d;
  logic [7:0]            char_q;
  logic                  eos_q;
  logic                  adv;
  clp_pkg::result_t      res;
  logic                  out_v_q, out_v_d;
  clp_pkg::kind_e        kind_q;
  logic [clp_pkg::ARG_W-1:0] a1_q, a2_q, a3_q;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign in_v_d        = (s_axis_tvalid && s_axis_tready) ? 1'b1 : (adv ? 1'b0 : in_v_q);
  assign out_v_d       = (adv && res.valid) ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_q);

  clp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .char_i   (char_q),
    .eos_i    (eos_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      char_q <= s_axis_tdata;
      eos_q  <= s_axis_tlast;
    end
    if (adv && res.valid) begin
      kind_q <= res.kind;
      a1_q   <= res.arg_first;
      a2_q   <= res.arg_second;
      a3_q   <= res.arg_third;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {2'b00, a3_q, a2_q, a1_q};

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !adv) |-> (out_v_q && !m_axis_tready))
    else $error("input stage stalled without a blocked result");

  a_error_args_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == clp_pkg::KIND_ERROR) |-> (m_axis_tdata == '0))
    else $error("error word carries nonzero arguments");

  a_clear_args: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == clp_pkg::KIND_CLEAR) |->
      (m_axis_tdata[103:34] == '0))
    else $error("clear word carries extra arguments");

endmodule
